// File: hw/rtl/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

    // Geometry
    localparam int ENTRIES    = 8;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W      = IDX_W;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int CAP_W      = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_LOOKUP = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type                     req_type;
        logic [KEY_BITS-1:0]           key;
        logic signed [VALUE_BITS-1:0]  value;
    } t_req;

    typedef struct packed {
        logic                          hit;
        logic signed [VALUE_BITS-1:0]  read_value;
        logic                          recent_valid;
        logic [KEY_BITS-1:0]           most_recent_key;
    } t_rsp;

    typedef struct packed {
        logic               hit;
        logic [ENTRIES-1:0] hit_oh;
    } t_match;

endpackage

`default_nettype wire

// File: hw/rtl/lkvc_match.sv
`default_nettype none

module lkvc_match (
    input  wire logic [lkvc_pkg::ENTRIES-1:0]  i_valid,
    input  wire logic [lkvc_pkg::KEY_BITS-1:0] i_keys [lkvc_pkg::ENTRIES],
    input  wire logic [lkvc_pkg::KEY_BITS-1:0] i_key,
    output lkvc_pkg::t_match                    o_match
);
    import lkvc_pkg::*;

    logic [ENTRIES-1:0] eq;

    // Compare every slot at once, keep the lowest matching one
    always_comb begin
        logic found;
        found          = 1'b0;
        o_match.hit_oh = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            eq[i] = i_valid[i] && (i_keys[i] == i_key);
            if (eq[i] && !found) begin
                o_match.hit_oh[i] = 1'b1;
                found             = 1'b1;
            end
        end
        o_match.hit = found;
    end

endmodule

`default_nettype wire

// File: hw/rtl/lkvc_entries.sv
`default_nettype none

module lkvc_entries (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire lkvc_pkg::t_req              i_req,
    input  wire logic [lkvc_pkg::CAP_W-1:0]  i_capacity,
    output lkvc_pkg::t_rsp                   o_rsp
);
    import lkvc_pkg::*;

    logic [KEY_BITS-1:0]          r_key   [ENTRIES];
    logic signed [VALUE_BITS-1:0] r_value [ENTRIES];
    logic [AGE_W-1:0]             r_age   [ENTRIES];
    logic [ENTRIES-1:0]           r_valid;
    logic [CNT_W-1:0]             r_used;

    logic [AGE_W-1:0]   n_age [ENTRIES];
    logic [ENTRIES-1:0] n_valid;
    logic [CNT_W-1:0]   n_used;

    t_match             match;
    logic [CNT_W-1:0]   cap_eff;
    logic [CNT_W-1:0]   cap_m1;
    logic               is_lookup;
    logic               insert_new;
    logic [AGE_W-1:0]   hit_age;
    logic [ENTRIES-1:0] kept;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] rank0;
    logic [KEY_BITS-1:0]          cur_recent;
    logic signed [VALUE_BITS-1:0] hit_value;

    lkvc_match u_match (
        .i_valid (r_valid),
        .i_keys  (r_key),
        .i_key   (i_req.key),
        .o_match (match)
    );

    // Clamp capacity into 1..ENTRIES
    always_comb begin
        if (i_capacity == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(i_capacity) > ENTRIES) begin
            cap_eff = CNT_W'(ENTRIES);
        end else begin
            cap_eff = CNT_W'(i_capacity);
        end
        cap_m1 = cap_eff - CNT_W'(1);
    end

    assign is_lookup  = (i_req.req_type == REQ_LOOKUP);
    assign insert_new = !is_lookup && !match.hit;

    // One-hot selects: hit slot age/value, current rank-0 key
    always_comb begin
        hit_age    = '0;
        hit_value  = '0;
        cur_recent = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            rank0[i] = r_valid[i] && (r_age[i] == '0);
            if (match.hit_oh[i]) begin
                hit_age   = hit_age | r_age[i];
                hit_value = hit_value | r_value[i];
            end
            if (rank0[i]) begin
                cur_recent = cur_recent | r_key[i];
            end
        end
    end

    // Drop entries ranked at or beyond cap-1, then pick the lowest free slot
    always_comb begin
        logic found;
        found   = 1'b0;
        free_oh = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            kept[i] = r_valid[i] && (CNT_W'(r_age[i]) < cap_m1);
            if (!kept[i] && !found) begin
                free_oh[i] = 1'b1;
                found      = 1'b1;
            end
        end
    end

    // Next recency ranks, valid marks and fill level
    always_comb begin
        n_valid = r_valid;
        n_used  = r_used;
        for (int i = 0; i < ENTRIES; i++) begin
            n_age[i] = r_age[i];
        end
        if (match.hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (match.hit_oh[i]) begin
                    n_age[i] = '0;
                end else if (r_valid[i] && r_age[i] < hit_age) begin
                    n_age[i] = AGE_W'(r_age[i] + 1'b1);
                end
            end
        end else if (insert_new) begin
            n_valid = kept | free_oh;
            n_used  = ((r_used >= cap_eff) ? cap_m1 : r_used) + CNT_W'(1);
            for (int i = 0; i < ENTRIES; i++) begin
                if (free_oh[i]) begin
                    n_age[i] = '0;
                end else if (kept[i]) begin
                    n_age[i] = AGE_W'(r_age[i] + 1'b1);
                end
            end
        end
    end

    always_comb begin
        o_rsp.hit        = match.hit;
        o_rsp.read_value = (match.hit && is_lookup) ? hit_value : '0;
        if (match.hit || insert_new) begin
            o_rsp.recent_valid    = 1'b1;
            o_rsp.most_recent_key = i_req.key;
        end else begin
            o_rsp.recent_valid    = (r_used != '0);
            o_rsp.most_recent_key = cur_recent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_advance) begin
            r_valid <= n_valid;
            r_used  <= n_used;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_advance && !is_lookup) begin
                if ((match.hit && match.hit_oh[i]) || (insert_new && free_oh[i])) begin
                    r_value[i] <= i_req.value;
                end
                if (insert_new && free_oh[i]) begin
                    r_key[i] <= i_req.key;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_used_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_used))
        else $error("fill level disagrees with valid marks");

    a_single_rank0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != '0) == $onehot(rank0))
        else $error("rank-0 entry not unique");

    a_lookup_miss_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && is_lookup && !match.hit |=> $stable(r_valid) && $stable(r_used))
        else $error("lookup miss changed the cache");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lru_key_value_cache.sv
`default_nettype none

// Channel | Direction | Handshake           | Beat
// --------+-----------+---------------------+------------------------------------
// in      | input     | i_in_valid/o_in_stall   | t_req: req_type, key, value
// out     | output    | o_out_valid/i_out_stall | t_rsp: hit, read_value,
//         |           |                     |        recent_valid, most_recent_key
// cfg     | input     | i_cfg_valid/o_cfg_ready | capacity (4 bits)
//
// One request per cycle sustained unless the output stalls; each beat passes through
// the input register, then key compare and rank update, into the result register.
// The entry table is updated in the same edge that loads the result, so the
// next request sees it at once.
// Synchronous active-low reset clears valid marks, ranks, fill level and sets
// capacity to 8; keys and values are not reset.
// A stall on the output holds the result and backs up into o_in_stall.

module lru_key_value_cache (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire lkvc_pkg::t_req              i_in_data,

    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output lkvc_pkg::t_rsp                   o_out_data,

    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [lkvc_pkg::CAP_W-1:0]  i_cfg_data
);
    import lkvc_pkg::*;

    logic             r_in_valid;
    t_req             r_in;
    logic             r_out_valid;
    t_rsp             r_out;
    logic [CAP_W-1:0] r_capacity;

    t_rsp rsp;
    logic out_blocked;
    logic advance;

    // Advance the input register into the result register unless the result
    // is still held by a stalled consumer.
    assign out_blocked = r_out_valid && i_out_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    lkvc_entries u_entries (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_req      (r_in),
        .i_capacity (r_capacity),
        .o_rsp      (rsp)
    );

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= CAP_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    // Payload: capture a beat when the input side is open, load the result on advance
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= rsp;
        end
    end

endmodule

`default_nettype wire
